@@ design/lwpf_pkg.sv @@
// ----------------------------------------------------------------------------
// LCD window pixel framer package
// Shared constants, codes, queue entry type and colour packing functions.
// ----------------------------------------------------------------------------
package lwpf_pkg;

  localparam int CoordWidthDefault = 9;
  localparam int CoordMaxWidth     = 16;
  localparam int CountWidth        = 19;
  localparam int StepWidth         = 4;

  localparam logic [CountWidth-1:0] PixelsMax = '1;

  localparam logic [7:0] CmdColumn = 8'h2A;
  localparam logic [7:0] CmdRow    = 8'h2B;
  localparam logic [7:0] CmdWrite  = 8'h2C;

  localparam logic [StepWidth-1:0] StepLastWindow = 4'd10;
  localparam logic [StepWidth-1:0] StepLastPixel  = 4'd1;

  typedef enum logic [1:0] {
    ActWindow   = 2'd0,
    ActPixelRgb = 2'd1,
    ActPixelRaw = 2'd2,
    ActNone     = 2'd3
  } action_e;

  typedef enum logic {
    KindWindow = 1'b0,
    KindPixel  = 1'b1
  } kind_e;

  // One queued piece of work for the byte sequencer.
  typedef struct packed {
    kind_e                    kind;
    logic [CoordMaxWidth-1:0] x_start;
    logic [CoordMaxWidth-1:0] y_start;
    logic [CoordMaxWidth-1:0] x_end;
    logic [CoordMaxWidth-1:0] y_end;
    logic [15:0]              word;
    logic                     full;
  } entry_t;

  // Rounds c * top / 255; the divide by 255 is exact for sums below 65535.
  function automatic logic [5:0] round_component(input logic [7:0] c,
                                                 input logic [5:0] top);
    logic [15:0] x;
    logic [15:0] q;
    x = 16'(c) * 16'(top) + 16'd127;
    q = (x + (x >> 8) + 16'd1) >> 8;
    return q[5:0];
  endfunction

  // Blue in the top five bits, green in six, red in the bottom five.
  function automatic logic [15:0] pack_rgb(input logic [7:0] r,
                                           input logic [7:0] g,
                                           input logic [7:0] b);
    logic [5:0] r5;
    logic [5:0] g6;
    logic [5:0] b5;
    r5 = round_component(r, 6'd31);
    g6 = round_component(g, 6'd63);
    b5 = round_component(b, 6'd31);
    return {b5[4:0], g6, r5[4:0]};
  endfunction

endpackage

@@ design/lwpf_front.sv @@
// ----------------------------------------------------------------------------
// LCD window pixel framer front end
// Accepts items, tracks the pixels left in the window and queues the work.
// ----------------------------------------------------------------------------
module lwpf_front import lwpf_pkg::*; #(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [CoordWidth-1:0] x_start_i,
  input  logic [CoordWidth-1:0] y_start_i,
  input  logic [CoordWidth-1:0] x_end_i,
  input  logic [CoordWidth-1:0] y_end_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [15:0]           raw_color_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output entry_t                push_entry_o
);

  localparam int DiffWidth = CoordWidth + 1;
  localparam int ProdWidth = 2 * DiffWidth;

  logic                  pending_q, pending_d;
  logic                  inverted_q, inverted_d;
  logic [ProdWidth-1:0]  product_q, product_d;
  logic [CountWidth-1:0] left_q, left_d;
  logic                  accept;
  logic [DiffWidth-1:0]  width_w;
  logic [DiffWidth-1:0]  height_w;
  logic [15:0]           word;

  // A window item holds the front in the cycle after it is taken, while its count settles.
  assign in_stall_o = pending_q || q_full_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign width_w  = {1'b0, x_end_i} - {1'b0, x_start_i} + DiffWidth'(1);
  assign height_w = {1'b0, y_end_i} - {1'b0, y_start_i} + DiffWidth'(1);

  assign word = (action_e'(action_i) == ActPixelRgb) ?
                pack_rgb(red_i, green_i, blue_i) : raw_color_i;

  always_comb begin
    pending_d    = 1'b0;
    inverted_d   = inverted_q;
    product_d    = product_q;
    left_d       = left_q;
    push_o       = 1'b0;
    push_entry_o = '0;
    push_entry_o.x_start = CoordMaxWidth'(x_start_i);
    push_entry_o.y_start = CoordMaxWidth'(y_start_i);
    push_entry_o.x_end   = CoordMaxWidth'(x_end_i);
    push_entry_o.y_end   = CoordMaxWidth'(y_end_i);
    push_entry_o.word    = word;
    if (pending_q) begin
      if (inverted_q) begin
        left_d = '0;
      end else if (product_q > ProdWidth'(PixelsMax)) begin
        left_d = PixelsMax;
      end else begin
        left_d = product_q[CountWidth-1:0];
      end
    end
    if (accept) begin
      case (action_e'(action_i))
        ActWindow: begin
          push_o            = 1'b1;
          push_entry_o.kind = KindWindow;
          pending_d         = 1'b1;
          inverted_d        = (x_end_i < x_start_i) || (y_end_i < y_start_i);
          product_d         = width_w * height_w;
        end
        ActPixelRgb, ActPixelRaw: begin
          if (left_q != '0) begin
            push_o            = 1'b1;
            push_entry_o.kind = KindPixel;
            push_entry_o.full = (left_q == CountWidth'(1));
            left_d            = left_q - CountWidth'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= 1'b0;
      left_q    <= '0;
    end else begin
      pending_q <= pending_d;
      left_q    <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    inverted_q <= inverted_d;
    product_q  <= product_d;
  end

endmodule

@@ design/lwpf_queue.sv @@
// ----------------------------------------------------------------------------
// LCD window pixel framer work queue
// Two-entry queue of work entries between the front end and the sequencer.
// ----------------------------------------------------------------------------
module lwpf_queue import lwpf_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t push_entry_i,
  input  logic   pop_i,
  output logic   full_o,
  output logic   head_valid_o,
  output entry_t head_o
);

  entry_t     slot_q [2];
  logic       rd_ptr_q, wr_ptr_q;
  logic [1:0] count_q;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

@@ design/lwpf_back.sv @@
// ----------------------------------------------------------------------------
// LCD window pixel framer byte sequencer
// Walks each queued entry out one byte per cycle, while the output is not stalled, into the output register.
// ----------------------------------------------------------------------------
module lwpf_back import lwpf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        head_valid_i,
  input  entry_t      head_i,
  output logic        pop_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        is_command_o,
  output logic        last_o,
  output logic        window_full_o
);

  logic [StepWidth-1:0] step_q, step_d;
  logic                 valid_q;
  logic [7:0]           byte_q, byte_d;
  logic                 cmd_q, cmd_d;
  logic                 last_q, last_d;
  logic                 full_q, full_d;
  logic                 advance;

  assign advance = !valid_q || !out_stall_i;

  always_comb begin
    byte_d = '0;
    cmd_d  = 1'b0;
    last_d = 1'b0;
    full_d = 1'b0;
    if (head_i.kind == KindPixel) begin
      byte_d = (step_q == StepLastPixel) ? head_i.word[7:0] : head_i.word[15:8];
      last_d = (step_q == StepLastPixel);
      full_d = (step_q == StepLastPixel) && head_i.full;
    end else begin
      case (step_q)
        4'd0:    begin byte_d = CmdColumn; cmd_d = 1'b1; end
        4'd1:    byte_d = head_i.x_start[15:8];
        4'd2:    byte_d = head_i.x_start[7:0];
        4'd3:    byte_d = head_i.x_end[15:8];
        4'd4:    byte_d = head_i.x_end[7:0];
        4'd5:    begin byte_d = CmdRow; cmd_d = 1'b1; end
        4'd6:    byte_d = head_i.y_start[15:8];
        4'd7:    byte_d = head_i.y_start[7:0];
        4'd8:    byte_d = head_i.y_end[15:8];
        4'd9:    byte_d = head_i.y_end[7:0];
        default: begin byte_d = CmdWrite; cmd_d = 1'b1; last_d = 1'b1; end
      endcase
    end
    pop_o  = advance && head_valid_i && last_d;
    step_d = step_q;
    if (advance && head_valid_i) begin
      step_d = last_d ? '0 : step_q + StepWidth'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      step_q <= step_d;
      if (advance) begin
        valid_q <= head_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      byte_q <= byte_d;
      cmd_q  <= cmd_d;
      last_q <= last_d;
      full_q <= full_d;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_byte_o    = byte_q;
  assign is_command_o  = cmd_q;
  assign last_o        = last_q;
  assign window_full_o = full_q;

endmodule

@@ design/lcd_window_pixel_framer_core.sv @@
// ----------------------------------------------------------------------------
// LCD window pixel framer
// Turns set-window and pixel items into the command/data byte stream of a
// display controller.
// ----------------------------------------------------------------------------
// The input channel takes one item per word: a set-window item or a pixel
// (RGB888 or raw 16-bit colour). The output channel gives one byte per word,
// with a command mark, a mark on the last byte of the item and a mark on the
// byte that completes the window.
// A set-window item gives eleven bytes and a pixel gives two bytes. The output
// register issues one byte a cycle while the output is not stalled.
// An accepted item is registered in the work queue, and its first byte is then
// registered in the output register, behind any entries already queued. A
// set-window item also holds the input while the new pixel count is formed
// from the registered product.
// Pixels that arrive while the count is zero, and items with the unused
// action code, are taken and dropped without any output.
// Reset empties the queue and output register and clears the pixel count.
// When the receiver stalls, the output byte holds, the two-entry queue fills,
// and then the input is stalled.
// ----------------------------------------------------------------------------
module lcd_window_pixel_framer_core import lwpf_pkg::*; #(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [1:0]            action_i,
  input  logic [CoordWidth-1:0] x_start_i,
  input  logic [CoordWidth-1:0] y_start_i,
  input  logic [CoordWidth-1:0] x_end_i,
  input  logic [CoordWidth-1:0] y_end_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [15:0]           raw_color_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  is_command_o,
  output logic                  last_o,
  output logic                  window_full_o
);

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  // Front end: classification, pixel count and colour packing.
  lwpf_front #(
    .CoordWidth(CoordWidth)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .x_start_i   (x_start_i),
    .y_start_i   (y_start_i),
    .x_end_i     (x_end_i),
    .y_end_i     (y_end_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .raw_color_i (raw_color_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_entry_o(push_entry)
  );

  // The queue lets the front end take items while the sequencer is busy.
  lwpf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_entry_i(push_entry),
    .pop_i       (pop),
    .full_o      (q_full),
    .head_valid_o(head_valid),
    .head_o      (head)
  );

  // Sequencer: one byte per cycle into the output register while the output is not stalled.
  lwpf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_byte_o   (out_byte_o),
    .is_command_o (is_command_o),
    .last_o       (last_o),
    .window_full_o(window_full_o)
  );

  // The completion mark only rides on the final data byte of a pixel.
  a_full_on_last_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && window_full_o |-> last_o && !is_command_o)
    else $error("window_full outside the last data byte of a pixel");

  // Command bytes are only ever the three controller commands.
  a_command_codes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_command_o |->
      out_byte_o == CmdColumn || out_byte_o == CmdRow || out_byte_o == CmdWrite)
    else $error("unexpected command byte");

  // The memory-write command closes every set-window item.
  a_write_is_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_command_o && out_byte_o == CmdWrite |-> last_o)
    else $error("memory-write command not marked last");

  // A taken window item blocks the input while its pixel count settles.
  a_window_holds_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && action_i == ActWindow |=> in_stall_o)
    else $error("input not held after a set-window item");

endmodule

@@ sim/lcd_window_pixel_framer_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window pixel framer checker
// Watches both channels of the framer, works out the byte stream that every
// accepted word should produce and compares each output word against it.
// ----------------------------------------------------------------------------
module lcd_window_pixel_framer_checker import lwpf_pkg::*; #(
  parameter int CoordWidth = CoordWidthDefault
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [1:0]            action_i,
  input  logic [CoordWidth-1:0] x_start_i,
  input  logic [CoordWidth-1:0] y_start_i,
  input  logic [CoordWidth-1:0] x_end_i,
  input  logic [CoordWidth-1:0] y_end_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic [15:0]           raw_color_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [7:0]            out_byte_i,
  input  logic                  is_command_i,
  input  logic                  last_i,
  input  logic                  window_full_i,
  output int                    mismatches_o,
  output int                    bytes_owed_o
);

  localparam int ReportLimit = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       cmd;
    logic       last;
    logic       full;
  } lcd_byte_t;

  lcd_byte_t             expected_bytes[$];
  logic [CountWidth-1:0] pixels_remaining;
  int                    mismatches = 0;
  int                    bytes_owed = 0;

  assign mismatches_o = mismatches;
  assign bytes_owed_o = bytes_owed;

  function automatic void push_byte(input logic [7:0] data, input logic cmd,
                                    input logic last, input logic full);
    lcd_byte_t entry;
    entry = '{data: data, cmd: cmd, last: last, full: full};
    expected_bytes.push_back(entry);
    bytes_owed++;
  endfunction

  // Rounds an 8-bit channel onto a range of 0..top_code.
  function automatic int unsigned scale_channel(input logic [7:0] c,
                                                input int unsigned top_code);
    return (32'(c) * top_code + 32'd127) / 32'd255;
  endfunction

  function automatic logic [15:0] rgb565_word(input logic [7:0] r, input logic [7:0] g,
                                              input logic [7:0] b);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    r5 = 5'(scale_channel(r, 31));
    g6 = 6'(scale_channel(g, 63));
    b5 = 5'(scale_channel(b, 31));
    return {b5, g6, r5};
  endfunction

  function automatic void frame_coord_pair(input logic [7:0] cmd_code,
                                           input logic [CoordWidth-1:0] first,
                                           input logic [CoordWidth-1:0] second);
    logic [15:0] a;
    logic [15:0] b;
    a = 16'(first);
    b = 16'(second);
    push_byte(cmd_code, 1'b1, 1'b0, 1'b0);
    push_byte(a[15:8], 1'b0, 1'b0, 1'b0);
    push_byte(a[7:0], 1'b0, 1'b0, 1'b0);
    push_byte(b[15:8], 1'b0, 1'b0, 1'b0);
    push_byte(b[7:0], 1'b0, 1'b0, 1'b0);
  endfunction

  // Expected bytes of one accepted word, and the new pixel count.
  function automatic void frame_word();
    longint unsigned area;
    logic [15:0]     word;
    case (action_e'(action_i))
      ActWindow: begin
        frame_coord_pair(CmdColumn, x_start_i, x_end_i);
        frame_coord_pair(CmdRow, y_start_i, y_end_i);
        push_byte(CmdWrite, 1'b1, 1'b1, 1'b0);
        if (x_end_i < x_start_i || y_end_i < y_start_i) begin
          pixels_remaining = '0;
        end else begin
          area = (64'(x_end_i) - 64'(x_start_i) + 64'd1)
               * (64'(y_end_i) - 64'(y_start_i) + 64'd1);
          pixels_remaining = (area > 64'(PixelsMax)) ? PixelsMax : area[CountWidth-1:0];
        end
      end
      ActPixelRgb, ActPixelRaw: begin
        if (pixels_remaining != '0) begin
          word = (action_e'(action_i) == ActPixelRgb) ?
                 rgb565_word(red_i, green_i, blue_i) : raw_color_i;
          pixels_remaining = pixels_remaining - 1'b1;
          push_byte(word[15:8], 1'b0, 1'b0, 1'b0);
          push_byte(word[7:0], 1'b0, 1'b1, pixels_remaining == '0);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void note_mismatch(input string what, input lcd_byte_t want,
                                        input lcd_byte_t got);
    mismatches++;
    if (mismatches <= ReportLimit) begin
      $display("%0t: %s: expected byte %h cmd %b last %b full %b, got byte %h cmd %b last %b full %b",
               $realtime, what, want.data, want.cmd, want.last, want.full,
               got.data, got.cmd, got.last, got.full);
    end
  endfunction

  // The output side is checked before the input side is framed, so a byte can
  // never be matched against a word taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    lcd_byte_t want;
    lcd_byte_t got;
    if (!rst_ni) begin
      expected_bytes.delete();
      pixels_remaining = '0;
      bytes_owed = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = '{data: out_byte_i, cmd: is_command_i, last: last_i, full: window_full_i};
        if (expected_bytes.size() == 0) begin
          note_mismatch("byte with nothing pending", '0, got);
        end else begin
          want = expected_bytes.pop_front();
          bytes_owed--;
          if (got.data !== want.data || got.cmd !== want.cmd ||
              got.last !== want.last || got.full !== want.full) begin
            note_mismatch("byte mismatch", want, got);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        frame_word();
      end
    end
  end

endmodule

@@ sim/tb_lcd_window_pixel_framer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LCD window pixel framer testbench
// Drives set-window and pixel words into the framer under random idling on
// both channels and leaves the byte-level checking to a separate checker.
// ----------------------------------------------------------------------------
module tb_lcd_window_pixel_framer_core;
  import lwpf_pkg::*;

  localparam int CoordWidth  = CoordWidthDefault;
  localparam int CoordMax    = (1 << CoordWidth) - 1;
  localparam int HalfPeriod  = 10;
  localparam int ResetCycles = 5;
  localparam int RandomItems = 80;
  // Even with 85 percent idling a legal run keeps moving words, so this many
  // quiet cycles in a row means a hang.
  localparam int QuietLimit  = 3000;
  localparam int DrainCycles = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            action;
  logic [CoordWidth-1:0] x_start;
  logic [CoordWidth-1:0] y_start;
  logic [CoordWidth-1:0] x_end;
  logic [CoordWidth-1:0] y_end;
  logic [7:0]            red;
  logic [7:0]            green;
  logic [7:0]            blue;
  logic [15:0]           raw_color;
  logic                  out_valid;
  logic                  out_stall;
  logic [7:0]            out_byte;
  logic                  is_command;
  logic                  last;
  logic                  window_full;

  int mismatches;
  int bytes_owed;

  // Idling percentages of the sender and the receiver in the current phase.
  int send_idle_pct = 31;
  int stall_pct     = 85;
  // Words of the random part that produce bytes; ignored words do not count.
  int counted_words = 0;
  int quiet_cycles  = 0;

  always begin
    #(HalfPeriod) clk = 1'b1;
    #(HalfPeriod) clk = 1'b0;
  end

  lcd_window_pixel_framer_core #(
    .CoordWidth(CoordWidth)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .action_i     (action),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .raw_color_i  (raw_color),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_o   (out_byte),
    .is_command_o (is_command),
    .last_o       (last),
    .window_full_o(window_full)
  );

  lcd_window_pixel_framer_checker #(
    .CoordWidth(CoordWidth)
  ) u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .action_i     (action),
    .x_start_i    (x_start),
    .y_start_i    (y_start),
    .x_end_i      (x_end),
    .y_end_i      (y_end),
    .red_i        (red),
    .green_i      (green),
    .blue_i       (blue),
    .raw_color_i  (raw_color),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_byte_i   (out_byte),
    .is_command_i (is_command),
    .last_i       (last),
    .window_full_i(window_full),
    .mismatches_o (mismatches),
    .bytes_owed_o (bytes_owed)
  );

  // The receiver decides at each falling edge whether to hold off the next
  // output word. With a zero percentage the output is never stalled.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Watchdog: counts edges at which neither channel moves a word. Sampling at
  // the rising edge sees the values from before the block's registers update.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
    end else begin
      quiet_cycles = 0;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // Offers one word on the input channel. It is entered at a falling edge and
  // returns at the falling edge after the word was taken, so the caller either
  // offers the next word there or lowers valid; valid is written once a step.
  task automatic send_item(input action_e act,
                           input logic [CoordWidth-1:0] xs, input logic [CoordWidth-1:0] ys,
                           input logic [CoordWidth-1:0] xe, input logic [CoordWidth-1:0] ye,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                           input logic [15:0] raw);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    action    <= act;
    x_start   <= xs;
    y_start   <= ys;
    x_end     <= xe;
    y_end     <= ye;
    red       <= r;
    green     <= g;
    blue      <= b;
    raw_color <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // A set-window word; the colour fields carry random values the block must ignore.
  task automatic send_window(input int unsigned xs, input int unsigned ys,
                             input int unsigned xe, input int unsigned ye);
    send_item(ActWindow, CoordWidth'(xs), CoordWidth'(ys), CoordWidth'(xe), CoordWidth'(ye),
              8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // A pixel word; the coordinate fields carry random values the block must ignore.
  task automatic send_pixel(input action_e act, input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [15:0] raw);
    send_item(act, CoordWidth'($urandom), CoordWidth'($urandom), CoordWidth'($urandom),
              CoordWidth'($urandom), r, g, b, raw);
  endtask

  // Lowers valid and waits until every byte owed so far has left the block.
  task automatic hold_for_drain();
    in_valid <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
  endtask

  // One random window followed by its pixels. Most bursts are small windows
  // filled exactly, so the full mark is hit often. Some stop one pixel short
  // to exercise a reload over pending pixels, some add one extra pixel that
  // must be dropped, and a few use inverted or large windows. A word with the
  // unused action code is slipped in now and then as noise.
  task automatic send_burst();
    int unsigned shape;
    int unsigned w;
    int unsigned h;
    int unsigned n;
    int unsigned k;
    int unsigned xs;
    int unsigned ys;
    int unsigned xe;
    int unsigned ye;
    shape = $urandom_range(0, 19);
    if (shape < 2) begin
      xs = $urandom_range(0, CoordMax);
      ys = $urandom_range(0, CoordMax);
      if ($urandom_range(0, 1) == 0) begin
        xs = $urandom_range(1, CoordMax);
        xe = $urandom_range(0, xs - 1);
        ye = $urandom_range(0, CoordMax);
      end else begin
        ys = $urandom_range(1, CoordMax);
        ye = $urandom_range(0, ys - 1);
        xe = $urandom_range(0, CoordMax);
      end
      n = 0;
      k = $urandom_range(0, 2);
    end else if (shape < 4) begin
      xs = $urandom_range(0, CoordMax / 2);
      xe = $urandom_range(xs, CoordMax);
      ys = $urandom_range(0, CoordMax / 2);
      ye = $urandom_range(ys, CoordMax);
      n  = (xe - xs + 1) * (ye - ys + 1);
      k  = $urandom_range(0, 4);
    end else begin
      w  = $urandom_range(1, 4);
      h  = $urandom_range(1, 3);
      xs = $urandom_range(0, CoordMax + 1 - w);
      ys = $urandom_range(0, CoordMax + 1 - h);
      xe = xs + w - 1;
      ye = ys + h - 1;
      n  = w * h;
      case ($urandom_range(0, 5))
        0:       k = n - 1;
        1:       k = n + 1;
        default: k = n;
      endcase
    end
    send_window(xs, ys, xe, ye);
    counted_words++;
    for (int unsigned i = 0; i < k; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_item(ActNone, CoordWidth'($urandom), CoordWidth'($urandom),
                  CoordWidth'($urandom), CoordWidth'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom), 16'($urandom));
      end
      send_pixel(($urandom_range(0, 1) == 0) ? ActPixelRgb : ActPixelRaw,
                 8'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
      if (i < n) begin
        counted_words++;
      end
    end
  endtask

  initial begin
    // Every input is known from time zero, while reset is held.
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    out_stall = 1'b0;
    action    = ActWindow;
    x_start   = '0;
    y_start   = '0;
    x_end     = '0;
    y_end     = '0;
    red       = '0;
    green     = '0;
    blue      = '0;
    raw_color = '0;
    repeat (ResetCycles) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. Right after reset the pixel count is zero, so a pixel is
    // dropped, and a word with the unused action code is ignored.
    send_pixel(ActPixelRgb, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(ActNone, CoordWidth'(CoordMax), CoordWidth'(CoordMax), CoordWidth'(CoordMax),
              CoordWidth'(CoordMax), 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    // A one-pixel window: the only pixel carries the full mark, the next one
    // is dropped.
    send_window(0, 0, 0, 0);
    send_pixel(ActPixelRgb, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    send_pixel(ActPixelRaw, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    // Inverted in x and then in y: all eleven bytes go out, yet the count is
    // zero and pixels are dropped.
    send_window(CoordMax, 0, 0, CoordMax);
    send_pixel(ActPixelRaw, 8'h5A, 8'hA5, 8'h3C, 16'hA5A5);
    send_window(0, CoordMax, CoordMax, 0);
    send_pixel(ActPixelRgb, 8'h80, 8'h40, 8'h20, 16'h5A5A);
    // The whole panel, with colour extremes and rounding corner values.
    send_window(0, 0, CoordMax, CoordMax);
    send_pixel(ActPixelRgb, 8'h00, 8'h00, 8'h00, 16'hFFFF);
    send_pixel(ActPixelRaw, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF);
    send_pixel(ActPixelRaw, 8'hFF, 8'hFF, 8'hFF, 16'h0000);
    send_pixel(ActPixelRgb, 8'h80, 8'h7F, 8'h01, 16'h0000);
    send_pixel(ActPixelRgb, 8'h04, 8'h08, 8'h10, 16'h0000);
    // A fresh window while the previous one is far from full: the count is
    // reloaded, so the second pixel here completes the window.
    send_window(100, 200, 101, 200);
    send_pixel(ActPixelRaw, 8'h00, 8'h00, 8'h00, 16'h1234);
    send_pixel(ActPixelRgb, 8'hFF, 8'h00, 8'hFF, 16'h0000);
    send_pixel(ActPixelRgb, 8'h12, 8'h34, 8'h56, 16'h0000);

    // The sender pauses until the directed bytes have all come out.
    hold_for_drain();

    // Random part in three phases: a slow receiver, then a slow sender, then
    // both at full rate.
    while (counted_words < RandomItems / 3) send_burst();
    send_idle_pct = 85;
    stall_pct     = 31;
    while (counted_words < 2 * RandomItems / 3) send_burst();
    hold_for_drain();
    send_idle_pct = 0;
    stall_pct     = 0;
    while (counted_words < RandomItems) send_burst();

    hold_for_drain();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && bytes_owed == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
